FILE: design/svlp_pkg.sv
// Shared types, constants and helpers of the state-variable lowpass bank.
`timescale 1ns / 1ps

package svlp_pkg;

   // Widths of the stored state, the multiplier and the accumulator.
   localparam int STATE_W = 48;
   localparam int HALF_W  = 24;
   localparam int OP_W    = 25;
   localparam int PROD_W  = 2 * OP_W;
   localparam int ACC_W   = 52;
   localparam int COEF_W  = 24;

   // Stream and register port widths.
   localparam int SAMPLE_W   = 16;
   localparam int CHAN_W     = 10;
   localparam int OUT_W      = 24;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from csr_paddr[3:2].
   localparam logic [1:0] REG_COEF_F = 2'd0;
   localparam logic [1:0] REG_COEF_Q = 2'd1;
   localparam logic [1:0] REG_GAIN   = 2'd2;

   localparam logic [COEF_W-1:0] COEF_F_RESET = 24'd4194;
   localparam logic [COEF_W-1:0] COEF_Q_RESET = 24'd2097152;
   localparam logic [COEF_W-1:0] GAIN_RESET   = 24'd65536;

   // How the registered product is scaled before it meets the accumulator.
   typedef enum logic [1:0] {
      SH_NONE,
      SH_L8,
      SH_L2,
      SH_R22
   } shift_type;

   typedef struct packed {
      logic      en;
      logic      load;
      logic      negate;
      shift_type shift;
   } mac_ctl_type;

   // Clamp an accumulator value to the signed state range.
   function automatic logic signed [STATE_W-1:0] sat_state(logic signed [ACC_W-1:0] v);
      logic same;
      same = (v[ACC_W-1:STATE_W-1] == {(ACC_W-STATE_W+1){v[ACC_W-1]}});
      if (same) begin
         return v[STATE_W-1:0];
      end else if (v[ACC_W-1]) begin
         return {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(STATE_W-1){1'b1}}};
      end
   endfunction

endpackage

FILE: design/svlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module svlp_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: design/svlp_mac.sv
// Shared 25x25 multiplier with a scaling, saturating accumulator.
`timescale 1ns / 1ps

module svlp_mac (
   input  logic                                  clock,
   input  logic signed [svlp_pkg::OP_W-1:0]      op_a,
   input  logic signed [svlp_pkg::OP_W-1:0]      op_b,
   input  logic signed [svlp_pkg::STATE_W-1:0]   init_value,
   input  svlp_pkg::mac_ctl_type                 ctl,
   output logic signed [svlp_pkg::STATE_W-1:0]   acc_sat
);

   logic signed [svlp_pkg::PROD_W-1:0] prod_ff;
   logic signed [svlp_pkg::ACC_W-1:0]  acc_ff;
   logic signed [svlp_pkg::ACC_W-1:0]  acc_in;
   logic signed [svlp_pkg::ACC_W-1:0]  prod_ext;
   logic signed [svlp_pkg::ACC_W-1:0]  term;
   logic signed [svlp_pkg::ACC_W-1:0]  base;

   assign prod_ext = svlp_pkg::ACC_W'(prod_ff);

   always_comb begin
      unique case (ctl.shift)
         svlp_pkg::SH_NONE: term = '0;
         svlp_pkg::SH_L8:   term = prod_ext <<< 8;
         svlp_pkg::SH_L2:   term = prod_ext <<< 2;
         svlp_pkg::SH_R22:  term = prod_ext >>> 22;
         default:           term = '0;
      endcase
      base   = ctl.load ? svlp_pkg::ACC_W'(init_value) : acc_ff;
      acc_in = ctl.negate ? (base - term) : (base + term);
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_sat = svlp_pkg::sat_state(acc_ff);

endmodule

FILE: design/state_variable_lowpass_bank.sv
// Top level of the bank of complex state-variable lowpass filters.
// A filter item's result is offered after the states READ, LOAD, CALC for both parts and
// FINISH, which waits while an earlier result is still held. Items are taken one at a
// time and only when idle, so a new item waits for the 18 steps that the single shared
// multiplier-accumulator spends on the real and imaginary parts. A clear item zeroes every
// state row; after reset the block runs this clearing pass before it accepts any item.
`timescale 1ns / 1ps

module state_variable_lowpass_bank #(
   parameter int CHANNELS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [9:0] channel, [25:10] sample_re, [41:26] sample_im, [47:42] zero
   input  logic [svlp_pkg::REQ_DATA_W-1:0]       req_tdata,
   // [0] action
   input  logic                                  req_tuser,

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [9:0] out_channel, [33:10] out_re, [57:34] out_im, [63:58] zero
   output logic [svlp_pkg::RSP_DATA_W-1:0]       rsp_tdata,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [svlp_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [svlp_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [svlp_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   // One memory row holds the whole state of a channel:
   // {low im, band im, low re, band re}, 48 bits each.
   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ROW_W  = 4 * svlp_pkg::STATE_W;
   localparam int CMP_W  = 17;
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CHANNELS - 1);

   // Micro-steps of one part. Each step up to STEP_SLO starts one multiplication, and each
   // step from STEP_QHI to STEP_TAIL folds the product of the previous step into the accumulator.
   localparam logic [3:0] STEP_GAIN = 4'd0;
   localparam logic [3:0] STEP_QHI  = 4'd1;
   localparam logic [3:0] STEP_QLO  = 4'd2;
   localparam logic [3:0] STEP_FHI  = 4'd3;
   localparam logic [3:0] STEP_FLO  = 4'd4;
   localparam logic [3:0] STEP_SHI  = 4'd5;
   localparam logic [3:0] STEP_SLO  = 4'd6;
   localparam logic [3:0] STEP_TAIL = 4'd7;
   localparam logic [3:0] STEP_DONE = 4'd8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_CALC,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic [3:0] step_ff;
   logic part_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   logic [svlp_pkg::CHAN_W-1:0] chan_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic signed [svlp_pkg::SAMPLE_W-1:0] sample_ff [2];
   logic signed [svlp_pkg::STATE_W-1:0] band_ff [2];
   logic signed [svlp_pkg::STATE_W-1:0] low_ff [2];
   logic signed [svlp_pkg::STATE_W-1:0] s_ff;
   logic signed [svlp_pkg::STATE_W-1:0] lnew_ff;

   logic [svlp_pkg::COEF_W-1:0] coef_f_ff;
   logic [svlp_pkg::COEF_W-1:0] coef_q_ff;
   logic [svlp_pkg::COEF_W-1:0] gain_ff;

   logic rsp_tvalid_ff;
   logic [svlp_pkg::CHAN_W-1:0] rsp_chan_ff;
   logic [svlp_pkg::OUT_W-1:0] rsp_re_ff;
   logic [svlp_pkg::OUT_W-1:0] rsp_im_ff;

   // Input item decode.
   logic req_fire;
   logic [svlp_pkg::CHAN_W-1:0] req_chan;
   logic [CMP_W-1:0] req_chan_ext;
   logic req_in_range;
   logic out_free;
   logic finish_fire;

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign req_chan     = req_tdata[9:0];
   assign req_chan_ext = CMP_W'(req_chan);
   assign req_in_range = (req_chan_ext < CMP_W'(CHANNELS));
   assign out_free     = !rsp_tvalid_ff || rsp_tready;
   assign finish_fire  = (state_ff == ST_FINISH) && out_free;

   // State memory.
   logic ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic [ROW_W-1:0] ram_rd_data;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = {low_ff[1], band_ff[1], low_ff[0], band_ff[0]};
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else if (finish_fire) begin
         ram_wr_en = 1'b1;
      end
   end

   svlp_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // Operand and accumulator selection for the current micro-step. For the
   // current part, z1 is the band state and lo the low state:
   //   s     = sat(lo - (x*gain << 8) + floor(z1*q >> 22))
   //   low'  = sat(lo + floor(z1*f >> 22))
   //   band' = sat(z1 - floor(s*f >> 22))
   // Each coefficient product splits z into a signed upper half and an unsigned
   // lower half, so floor(z*c >> 22) = (hi*c << 2) + (lo*c >> 22).
   logic signed [svlp_pkg::STATE_W-1:0] cur_z1;
   logic signed [svlp_pkg::STATE_W-1:0] cur_lo;
   logic signed [svlp_pkg::OP_W-1:0] op_a;
   logic signed [svlp_pkg::OP_W-1:0] op_b;
   logic signed [svlp_pkg::STATE_W-1:0] init_value;
   svlp_pkg::mac_ctl_type mac_ctl;
   logic signed [svlp_pkg::STATE_W-1:0] acc_sat;

   assign cur_z1 = band_ff[part_ff];
   assign cur_lo = low_ff[part_ff];

   always_comb begin
      op_a       = '0;
      op_b       = '0;
      init_value = cur_lo;
      mac_ctl    = '{en: 1'b0, load: 1'b0, negate: 1'b0, shift: svlp_pkg::SH_NONE};
      if (state_ff == ST_CALC) begin
         mac_ctl.en = 1'b1;
         unique case (step_ff)
            STEP_GAIN: begin
               op_a    = svlp_pkg::OP_W'(sample_ff[part_ff]);
               op_b    = {1'b0, gain_ff};
               mac_ctl = '{en: 1'b1, load: 1'b1, negate: 1'b0, shift: svlp_pkg::SH_NONE};
            end
            STEP_QHI: begin
               op_a    = svlp_pkg::OP_W'($signed(cur_z1[47:24]));
               op_b    = {1'b0, coef_q_ff};
               mac_ctl = '{en: 1'b1, load: 1'b0, negate: 1'b1, shift: svlp_pkg::SH_L8};
            end
            STEP_QLO: begin
               op_a    = {1'b0, cur_z1[23:0]};
               op_b    = {1'b0, coef_q_ff};
               mac_ctl = '{en: 1'b1, load: 1'b0, negate: 1'b0, shift: svlp_pkg::SH_L2};
            end
            STEP_FHI: begin
               op_a    = svlp_pkg::OP_W'($signed(cur_z1[47:24]));
               op_b    = {1'b0, coef_f_ff};
               mac_ctl = '{en: 1'b1, load: 1'b0, negate: 1'b0, shift: svlp_pkg::SH_R22};
            end
            STEP_FLO: begin
               op_a    = {1'b0, cur_z1[23:0]};
               op_b    = {1'b0, coef_f_ff};
               mac_ctl = '{en: 1'b1, load: 1'b1, negate: 1'b0, shift: svlp_pkg::SH_L2};
            end
            STEP_SHI: begin
               op_a    = svlp_pkg::OP_W'($signed(s_ff[47:24]));
               op_b    = {1'b0, coef_f_ff};
               mac_ctl = '{en: 1'b1, load: 1'b0, negate: 1'b0, shift: svlp_pkg::SH_R22};
            end
            STEP_SLO: begin
               op_a       = {1'b0, s_ff[23:0]};
               op_b       = {1'b0, coef_f_ff};
               init_value = cur_z1;
               mac_ctl    = '{en: 1'b1, load: 1'b1, negate: 1'b1, shift: svlp_pkg::SH_L2};
            end
            STEP_TAIL: begin
               mac_ctl = '{en: 1'b1, load: 1'b0, negate: 1'b1, shift: svlp_pkg::SH_R22};
            end
            default: begin
               mac_ctl.en = 1'b0;
            end
         endcase
      end
   end

   svlp_mac u_mac (
      .clock      (clock),
      .op_a       (op_a),
      .op_b       (op_b),
      .init_value (init_value),
      .ctl        (mac_ctl),
      .acc_sat    (acc_sat)
   );

   // Sequencer, working registers and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         step_ff       <= STEP_GAIN;
         part_ff       <= 1'b0;
         clr_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // A result taken in the same cycle as a new one is loaded stays valid.
         if (rsp_tvalid_ff && rsp_tready && !finish_fire) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (clr_cnt_ff == ADDR_LAST) begin
                  clr_cnt_ff <= '0;
                  state_ff   <= ST_IDLE;
               end else begin
                  clr_cnt_ff <= clr_cnt_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  chan_ff      <= req_chan;
                  addr_ff      <= req_chan_ext[ADDR_W-1:0];
                  sample_ff[0] <= req_tdata[25:10];
                  sample_ff[1] <= req_tdata[41:26];
                  if (req_tuser) begin
                     state_ff <= ST_CLEAR;
                  end else if (req_in_range) begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               band_ff[0] <= ram_rd_data[47:0];
               low_ff[0]  <= ram_rd_data[95:48];
               band_ff[1] <= ram_rd_data[143:96];
               low_ff[1]  <= ram_rd_data[191:144];
               step_ff    <= STEP_GAIN;
               part_ff    <= 1'b0;
               state_ff   <= ST_CALC;
            end
            ST_CALC: begin
               if (step_ff == STEP_FLO) begin
                  s_ff <= acc_sat;
               end
               if (step_ff == STEP_SLO) begin
                  lnew_ff <= acc_sat;
               end
               if (step_ff == STEP_DONE) begin
                  band_ff[part_ff] <= acc_sat;
                  low_ff[part_ff]  <= lnew_ff;
                  step_ff          <= STEP_GAIN;
                  part_ff          <= 1'b1;
                  if (part_ff) begin
                     state_ff <= ST_FINISH;
                  end
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_chan_ff   <= chan_ff;
                  rsp_re_ff     <= low_ff[0][47:24];
                  rsp_im_ff     <= low_ff[1][47:24];
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, rsp_im_ff, rsp_re_ff, rsp_chan_ff};

   // Configuration registers. Writes land on the access cycle. The user must write them
   // only between items; the block itself does not enforce this.
   logic csr_write;
   logic [1:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_f_ff <= svlp_pkg::COEF_F_RESET;
         coef_q_ff <= svlp_pkg::COEF_Q_RESET;
         gain_ff   <= svlp_pkg::GAIN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            svlp_pkg::REG_COEF_F: coef_f_ff <= csr_pwdata[23:0];
            svlp_pkg::REG_COEF_Q: coef_q_ff <= csr_pwdata[23:0];
            svlp_pkg::REG_GAIN:   gain_ff   <= csr_pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         svlp_pkg::REG_COEF_F: csr_prdata = {8'b0, coef_f_ff};
         svlp_pkg::REG_COEF_Q: csr_prdata = {8'b0, coef_q_ff};
         svlp_pkg::REG_GAIN:   csr_prdata = {8'b0, gain_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // A new result only appears at the end of a filter item.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish state");

   // No item is taken while the state memory is being cleared.
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("input ready during clearing pass");

   // The micro-step counter stays within one part's schedule.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> (step_ff <= STEP_DONE))
      else $error("micro-step counter out of range");

   // An in-range filter item goes straight to the state read.
   a_filter_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tuser && req_in_range) |=> (state_ff == ST_READ))
      else $error("accepted filter item did not start a state read");

   // A waiting result is never overwritten before it is taken.
   a_rsp_not_lost: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |=> ($stable(rsp_re_ff) && $stable(rsp_im_ff)))
      else $error("pending result overwritten");

endmodule
